### rtl/core/tdfe_pkg.sv
`timescale 1ns / 1ps
package tdfe_pkg;

	localparam int ROWS_DEF = 4;
	localparam int ROW_LEN  = 68;
	localparam int BLK_LEN  = 17;
	localparam int CELL_CHARS = 8;
	localparam int HDR_LEN  = 8;
	localparam int MSG_LEN  = 77;

	localparam logic [7:0] SPACE_CHR = 8'h20;
	localparam logic [7:0] GL_FULL   = 8'h05;
	localparam logic [7:0] GL_HALF   = 8'h03;
	localparam logic [7:0] GL_HALF_L = 8'h04;
	localparam logic [7:0] GL_EMPTY  = 8'h06;
	localparam logic [7:0] ROW_CODE  = 8'h18;
	localparam logic [7:0] END_BYTE  = 8'hF7;

	typedef enum logic [2:0] {
		REQ_TEXT   = 3'd0,
		REQ_BAR_U  = 3'd1,
		REQ_BAR_B  = 3'd2,
		REQ_CLEAR  = 3'd3,
		REQ_LOCK   = 3'd4,
		REQ_UNLOCK = 3'd5,
		REQ_TICK   = 3'd6,
		REQ_NONE   = 3'd7
	} req_t;

	typedef enum logic [1:0] {
		RGN_ROW   = 2'd0,
		RGN_BLOCK = 2'd1,
		RGN_CELL  = 2'd2,
		RGN_NONE  = 2'd3
	} rgn_t;

	typedef enum logic [2:0] {
		S_CLR, S_IDLE, S_WRITE, S_SNAP, S_SNAPW, S_SREAD, S_EMIT
	} st_t;

	function automatic logic [6:0] cell_base(input logic [2:0] c);
		logic [6:0] b;
		b = 7'(c[2:1]) * 7'(BLK_LEN) + (c[0] ? 7'(CELL_CHARS + 1) : 7'd0);
		return b;
	endfunction

	function automatic logic [7:0] hdr_byte(input logic [2:0] p);
		logic [7:0] b;
		case (p)
			3'd0: b = 8'hF0;
			3'd1: b = 8'h47;
			3'd2: b = 8'h7F;
			3'd3: b = 8'h15;
			3'd4: b = ROW_CODE;
			3'd6: b = 8'h45;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	function automatic logic [7:0] bar_glyph(input logic [2:0] k, input logic [6:0] v,
			input logic bip);
		logic [7:0] vp;
		logic [4:0] n;
		logic [3:0] f;
		logic [3:0] kk;
		logic [7:0] g;
		vp = {1'b0, v} + 8'd1;
		n  = vp[7:3];
		kk = {1'b0, k};
		g  = GL_EMPTY;
		if (!bip) begin
			f = n[4:1];
			if (kk < f) g = GL_FULL;
			else if (kk == f && n[0]) g = GL_HALF;
		end else if (v > 7'd64) begin
			n = n - 5'd8;
			f = n[4:1];
			if (kk >= 4'd4 && kk < 4'd4 + f) g = GL_FULL;
			else if (kk == 4'd4 || (n[0] && kk == 4'd4 + f)) g = GL_HALF;
		end else begin
			n = 5'd8 - n;
			f = n[4:1];
			if (kk + f >= 4'd4 && kk < 4'd4) g = GL_FULL;
			else if (kk == 4'd4) g = GL_HALF;
			else if (n[0] && kk + f == 4'd3) g = GL_HALF_L;
		end
		return g;
	endfunction

endpackage

### rtl/core/tdfe_if.sv
`timescale 1ns / 1ps
interface tdfe_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] req_type;
	logic [1:0] row;
	logic [1:0] text_region;
	logic [2:0] region_index;
	logic [7:0] char_code;
	logic       char_valid;
	logic       first_char;
	logic       last_char;
	logic [6:0] bar_value;
	logic       out_idle;

	modport source (output valid, req_type, row, text_region, region_index, char_code,
		char_valid, first_char, last_char, bar_value, out_idle, input ready);
	modport sink (input valid, req_type, row, text_region, region_index, char_code,
		char_valid, first_char, last_char, bar_value, out_idle, output ready);
endinterface

interface tdfe_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [1:0] frame_row;
	logic       frame_last;

	modport source (output valid, out_byte, frame_row, frame_last, input ready);
	modport sink (input valid, out_byte, frame_row, frame_last, output ready);
endinterface

### rtl/core/tdfe_ram.sv
`timescale 1ns / 1ps
module tdfe_ram #(
	parameter int DEPTH = 68,
	parameter int WIDTH = 8,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
	end

	// registered read
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end
endmodule

### rtl/core/text_display_frame_engine_core.sv
`timescale 1ns / 1ps
// Text display frame engine.
// Channels: req (sink) carries one request word per handshake: a text
// character, a bar level, a row clear, a lock/unlock or a tick. rsp (source)
// carries one framed message byte per handshake, with its row and an end flag.
// A message is F0 47 7F 15 18+row 00 45 00, the 68 snapshot bytes, then F7.
// Sequencing: a single text character is written in its accept cycle; a run
// end, bar, or clear walks the text store one entry per cycle, all on the
// store's single write port. A tick that starts a message copies the row to
// the snapshot memory; then each tick reads the snapshot (S_SREAD) and loads
// its byte into the output register (S_EMIT). One request is in flight at a
// time; req.ready is low while it is worked.
// Reset: after arst_n releases, a clearing pass writes spaces to all
// ROWS*68 store entries with req.ready low; all rows start dirty and
// unlocked.
// Stall: the result sits in an output register. A new request is accepted
// while it waits; a tick that needs the register holds until rsp.ready.
module text_display_frame_engine_core
	import tdfe_pkg::*;
#(
	parameter int ROWS = ROWS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	tdfe_req_if.sink   req,
	tdfe_rsp_if.source rsp
);
	localparam int DEPTH = ROWS * ROW_LEN;
	localparam int AW    = $clog2(DEPTH);
	localparam int SAW   = $clog2(ROW_LEN);
	localparam int RIW   = (ROWS > 1) ? $clog2(ROWS) : 1;

	st_t state_q, state_d;

	logic [ROWS-1:0] dirty_q, lock_q;
	logic            sending_q;
	logic [6:0]      pos_q;
	logic [RIW-1:0]  srow_q;
	logic [6:0]      cur_q;
	logic [AW-1:0]   clr_q;
	logic [AW-1:0]   base_q;
	logic [6:0]      k_q, end_q;
	logic            gmode_q, bip_q;
	logic [6:0]      v_q;

	logic            snap_we_s1;
	logic [SAW-1:0]  snap_idx_s1;

	logic            ovalid_q;
	logic [7:0]      obyte_q;
	logic [1:0]      orow_q;
	logic            olast_q;

	logic            st_we;
	logic [AW-1:0]   st_waddr, st_raddr;
	logic [7:0]      st_wdata, st_rdata;
	logic [SAW-1:0]  sn_raddr;
	logic [7:0]      sn_rdata;

	tdfe_ram #(.DEPTH(DEPTH), .WIDTH(8)) u_store (
		.clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
		.raddr(st_raddr), .rdata(st_rdata)
	);

	tdfe_ram #(.DEPTH(ROW_LEN), .WIDTH(8)) u_snap (
		.clk(clk), .we(snap_we_s1), .waddr(snap_idx_s1), .wdata(st_rdata),
		.raddr(sn_raddr), .rdata(sn_rdata)
	);

	// request decode
	req_t          rtype;
	logic          acc, row_ok;
	logic [ROWS-1:0] row_bit;
	logic [AW-1:0] row_base;
	logic [6:0]    rg_base, rg_len, pad_end, pad_start, c0, c1;
	logic          rg_ok, blank9, txt_wr;
	logic          pick_ok;
	logic [RIW-1:0] pick_row;
	logic          load_out, out_free;

	assign rtype    = req_t'(req.req_type);
	assign acc      = req.valid && req.ready;
	assign row_ok   = 32'(req.row) < ROWS;
	assign row_bit  = ROWS'(1) << req.row;
	assign row_base = AW'(32'(req.row) * ROW_LEN);
	assign out_free = !ovalid_q || rsp.ready;

	always_comb begin
		rg_ok   = 1'b1;
		rg_base = '0;
		rg_len  = 7'(ROW_LEN);
		blank9  = 1'b0;
		unique case (rgn_t'(req.text_region))
			RGN_ROW: begin
			end
			RGN_BLOCK: begin
				rg_base = 7'(req.region_index[1:0]) * 7'(BLK_LEN);
				rg_len  = 7'(BLK_LEN);
			end
			RGN_CELL: begin
				rg_base = cell_base(req.region_index);
				rg_len  = 7'(CELL_CHARS);
				blank9  = !req.region_index[0];
			end
			RGN_NONE: rg_ok = 1'b0;
			default: rg_ok = 1'b0;
		endcase
		pad_end = blank9 ? 7'(CELL_CHARS + 1) : rg_len;
		c0      = req.first_char ? 7'd0 : cur_q;
		txt_wr  = req.char_valid && (c0 < rg_len);
		c1      = c0 + (txt_wr ? 7'd1 : 7'd0);
		// a cursor past the cell end still blanks the even cell's ninth character
		pad_start = (blank9 && c1 > 7'(CELL_CHARS)) ? 7'(CELL_CHARS) : c1;
	end

	// lowest dirty, unlocked row
	always_comb begin
		pick_ok  = 1'b0;
		pick_row = '0;
		for (int r = ROWS - 1; r >= 0; r--) begin
			if (dirty_q[r] && !lock_q[r]) begin
				pick_ok  = 1'b1;
				pick_row = RIW'(r);
			end
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLR;
		else state_q <= state_d;
	end

	// next state and store port control
	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		st_we     = 1'b0;
		st_waddr  = base_q + AW'(k_q);
		st_wdata  = SPACE_CHR;
		st_raddr  = base_q + AW'(k_q);
		load_out  = 1'b0;
		unique case (state_q)
			S_CLR: begin
				st_we    = 1'b1;
				st_waddr = clr_q;
				if (32'(clr_q) == DEPTH - 1) state_d = S_IDLE;
			end
			S_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					case (rtype)
						REQ_TEXT: begin
							if (row_ok && rg_ok) begin
								st_we    = txt_wr;
								st_waddr = row_base + AW'(rg_base) + AW'(c0);
								st_wdata = req.char_code;
								if (req.last_char && pad_start < pad_end) state_d = S_WRITE;
							end
						end
						REQ_BAR_U, REQ_BAR_B, REQ_CLEAR: begin
							if (row_ok) state_d = S_WRITE;
						end
						REQ_TICK: begin
							if (sending_q) state_d = S_SREAD;
							else if (req.out_idle && pick_ok) state_d = S_SNAP;
						end
						default: begin
						end
					endcase
				end
			end
			S_WRITE: begin
				st_we = 1'b1;
				if (gmode_q && k_q < 7'(CELL_CHARS)) st_wdata = bar_glyph(k_q[2:0], v_q, bip_q);
				if (k_q + 7'd1 == end_q) state_d = S_IDLE;
			end
			S_SNAP: begin
				if (k_q == 7'(ROW_LEN - 1)) state_d = S_SNAPW;
			end
			S_SNAPW: state_d = S_SREAD;
			S_SREAD: state_d = S_EMIT;
			S_EMIT: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	assign sn_raddr = SAW'(pos_q - 7'(HDR_LEN));

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dirty_q     <= '1;
			lock_q      <= '0;
			sending_q   <= 1'b0;
			pos_q       <= '0;
			srow_q      <= '0;
			cur_q       <= '0;
			clr_q       <= '0;
			k_q         <= '0;
			snap_we_s1  <= 1'b0;
			ovalid_q    <= 1'b0;
		end else begin
			snap_we_s1 <= (state_q == S_SNAP);
			if (state_q == S_CLR) clr_q <= clr_q + AW'(1);
			if (state_q == S_WRITE || state_q == S_SNAP) k_q <= k_q + 7'd1;
			if (acc) begin
				case (rtype)
					REQ_TEXT: begin
						if (row_ok && rg_ok) begin
							cur_q <= req.last_char ? 7'd0 : c1;
							k_q   <= pad_start;
							if (req.last_char) dirty_q <= dirty_q | row_bit;
						end
					end
					REQ_BAR_U, REQ_BAR_B, REQ_CLEAR: begin
						k_q <= '0;
						if (row_ok) dirty_q <= dirty_q | row_bit;
					end
					REQ_LOCK: if (row_ok) lock_q <= lock_q | row_bit;
					REQ_UNLOCK: if (row_ok) lock_q <= lock_q & ~row_bit;
					REQ_TICK: begin
						if (!sending_q && req.out_idle && pick_ok) begin
							dirty_q   <= dirty_q & ~(ROWS'(1) << pick_row);
							sending_q <= 1'b1;
							pos_q     <= '0;
							srow_q    <= pick_row;
							k_q       <= '0;
						end
					end
					default: begin
					end
				endcase
			end
			if (load_out) begin
				ovalid_q <= 1'b1;
				if (pos_q == 7'(MSG_LEN - 1)) begin
					sending_q <= 1'b0;
					pos_q     <= '0;
				end else begin
					pos_q <= pos_q + 7'd1;
				end
			end else if (rsp.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// payload registers: region setup, snapshot pipe, output word
	always_ff @(posedge clk) begin
		snap_idx_s1 <= SAW'(k_q);
		if (acc) begin
			v_q   <= req.bar_value;
			bip_q <= (rtype == REQ_BAR_B);
			case (rtype)
				REQ_TEXT: begin
					base_q  <= row_base + AW'(rg_base);
					end_q   <= pad_end;
					gmode_q <= 1'b0;
				end
				REQ_BAR_U, REQ_BAR_B: begin
					base_q  <= row_base + AW'(cell_base(req.region_index));
					end_q   <= req.region_index[0] ? 7'(CELL_CHARS) : 7'(CELL_CHARS + 1);
					gmode_q <= 1'b1;
				end
				REQ_CLEAR: begin
					base_q  <= row_base;
					end_q   <= 7'(ROW_LEN);
					gmode_q <= 1'b0;
				end
				REQ_TICK: base_q <= AW'(32'(pick_row) * ROW_LEN);
				default: begin
				end
			endcase
		end
		if (load_out) begin
			orow_q  <= 2'(srow_q);
			olast_q <= (pos_q == 7'(MSG_LEN - 1));
			if (pos_q == 7'd4) obyte_q <= ROW_CODE + 8'(srow_q);
			else if (pos_q < 7'(HDR_LEN)) obyte_q <= hdr_byte(pos_q[2:0]);
			else if (pos_q < 7'(HDR_LEN + ROW_LEN)) obyte_q <= sn_rdata;
			else obyte_q <= END_BYTE;
		end
	end

	assign rsp.valid      = ovalid_q;
	assign rsp.out_byte   = obyte_q;
	assign rsp.frame_row  = orow_q;
	assign rsp.frame_last = olast_q;

	a_clr_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLR |-> !req.ready) else $error("request taken during clear pass");
	a_snap_sending: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SNAP |-> sending_q) else $error("snapshot copy without message");
	a_load_sending: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> sending_q) else $error("byte emitted with no message");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && pos_q == 7'(MSG_LEN - 1)) |=> !sending_q)
		else $error("message did not end on closing byte");
endmodule
